@@ rtl/array_linked_list_engine_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the array linked list engine.
// Each macro expands to one labeled concurrent assertion with a reset guard.
// ---------------------------------------------------------------------------
`ifndef ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define ALLE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ALLE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/alle_pkg.sv @@
// ---------------------------------------------------------------------------
// alle_pkg
// Shared codes, widths and control bundles of the array linked list engine.
// ---------------------------------------------------------------------------
package alle_pkg;

	// Fixed field widths.
	localparam int VAL_W     = 8;
	localparam int OP_W      = 2;
	localparam int STAT_W    = 2;
	localparam int SLOTOUT_W = 4;
	localparam int CNTOUT_W  = 5;
	localparam int CAP_W     = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd5;

	// Operation codes of an input item.
	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

	// Update commands broadcast to the cell row.
	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_APPEND,
		CMD_DELETE,
		CMD_MODIFY
	} cmd_kind_t;

	// Search token that travels down the cell row.
	typedef struct packed {
		logic             vld;
		logic             found;
		logic [VAL_W-1:0] key;
	} tok_ctl_t;

	// Update command for the cell row.
	typedef struct packed {
		cmd_kind_t        kind;
		logic [VAL_W-1:0] value;
	} cmd_ctl_t;

endpackage

@@ rtl/alle_cell.sv @@
// ---------------------------------------------------------------------------
// alle_cell
// One list position: holds the slot number and value of the node at that
// position, checks the passing search token and shifts on delete.
// ---------------------------------------------------------------------------
module alle_cell #(
	parameter int N   = 16,
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  alle_pkg::tok_ctl_t          tok_in,
	input  logic [$clog2(N)-1:0]        tok_pos_in,
	input  logic [$clog2(N)-1:0]        tok_slot_in,
	output alle_pkg::tok_ctl_t          tok_out,
	output logic [$clog2(N)-1:0]        tok_pos_out,
	output logic [$clog2(N)-1:0]        tok_slot_out,
	input  alle_pkg::cmd_ctl_t          cmd,
	input  logic [$clog2(N)-1:0]        cmd_pos,
	input  logic [$clog2(N)-1:0]        cmd_slot,
	input  logic                        nxt_occ,
	input  logic [$clog2(N)-1:0]        nxt_slot,
	input  logic [alle_pkg::VAL_W-1:0]  nxt_val,
	output logic                        occ,
	output logic [$clog2(N)-1:0]        slot,
	output logic [alle_pkg::VAL_W-1:0]  val
);
	import alle_pkg::*;

	localparam int IW = $clog2(N);
	localparam logic [IW-1:0] MY_POS = IW'(IDX);

	logic          occ_q;
	logic [IW-1:0] slot_q;
	logic [VAL_W-1:0] val_q;
	logic          tok_vld_q;
	logic          tok_found_q;
	logic [VAL_W-1:0] tok_key_q;
	logic [IW-1:0] tok_pos_q;
	logic [IW-1:0] tok_slot_q;
	logic          hit;

	// This position matches when it holds a node with the key and no
	// earlier position has matched.
	assign hit = tok_in.vld && !tok_in.found && occ_q && (val_q == tok_in.key);

	// Token valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
		end
	end

	// Token payload, marked with this position on a match.
	always_ff @(posedge clk) begin
		tok_key_q <= tok_in.key;
		if (hit) begin
			tok_found_q <= 1'b1;
			tok_pos_q   <= MY_POS;
			tok_slot_q  <= slot_q;
		end else begin
			tok_found_q <= tok_in.found;
			tok_pos_q   <= tok_pos_in;
			tok_slot_q  <= tok_slot_in;
		end
	end

	// Occupied flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			unique case (cmd.kind)
				CMD_APPEND: begin
					if (cmd_pos == MY_POS) occ_q <= 1'b1;
				end
				CMD_DELETE: begin
					if (MY_POS >= cmd_pos) occ_q <= nxt_occ;
				end
				CMD_MODIFY, CMD_NONE: begin
					occ_q <= occ_q;
				end
				default: begin
					occ_q <= occ_q;
				end
			endcase
		end
	end

	// Node contents; on delete every later position moves one place forward.
	always_ff @(posedge clk) begin
		unique case (cmd.kind)
			CMD_APPEND: begin
				if (cmd_pos == MY_POS) begin
					slot_q <= cmd_slot;
					val_q  <= cmd.value;
				end
			end
			CMD_DELETE: begin
				if (MY_POS >= cmd_pos) begin
					slot_q <= nxt_slot;
					val_q  <= nxt_val;
				end
			end
			CMD_MODIFY: begin
				if (cmd_pos == MY_POS) val_q <= cmd.value;
			end
			CMD_NONE: begin
				val_q <= val_q;
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

	assign tok_out.vld   = tok_vld_q;
	assign tok_out.found = tok_found_q;
	assign tok_out.key   = tok_key_q;
	assign tok_pos_out   = tok_pos_q;
	assign tok_slot_out  = tok_slot_q;
	assign occ           = occ_q;
	assign slot          = slot_q;
	assign val           = val_q;

endmodule

@@ rtl/alle_ctrl.sv @@
// ---------------------------------------------------------------------------
// alle_ctrl
// Sequencer of the engine: takes items, launches the search token, scans
// for the lowest free slot, applies the update and holds the result item.
// ---------------------------------------------------------------------------
`include "array_linked_list_engine_assert.svh"

module alle_ctrl #(
	parameter int N = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [alle_pkg::OP_W-1:0]      opcode,
	input  logic [alle_pkg::VAL_W-1:0]     key_value,
	input  logic [alle_pkg::VAL_W-1:0]     new_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [alle_pkg::STAT_W-1:0]    status,
	output logic [alle_pkg::SLOTOUT_W-1:0] slot_used,
	output logic [alle_pkg::CNTOUT_W-1:0]  entry_count,
	input  logic                           wr_en,
	input  logic [alle_pkg::CAP_W-1:0]     wr_data,
	output alle_pkg::tok_ctl_t             tok_start,
	input  alle_pkg::tok_ctl_t             tok_end,
	input  logic [$clog2(N)-1:0]           tok_end_pos,
	input  logic [$clog2(N)-1:0]           tok_end_slot,
	output alle_pkg::cmd_ctl_t             cmd,
	output logic [$clog2(N)-1:0]           cmd_pos,
	output logic [$clog2(N)-1:0]           cmd_slot
);
	import alle_pkg::*;

	localparam int IW = $clog2(N);
	localparam int CW = $clog2(N + 1);
	localparam int KW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [KW-1:0] LIM = KW'(N);
	localparam logic [CW-1:0] SCAN_END = CW'(N);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_WALK   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0]       state_q;
	logic [OP_W-1:0]  op_q;
	logic [VAL_W-1:0] key_q;
	logic [VAL_W-1:0] new_q;
	logic             launch_q;
	logic [CW-1:0]    scan_q;
	logic             free_found_q;
	logic [IW-1:0]    free_slot_q;
	logic             found_q;
	logic [IW-1:0]    hit_pos_q;
	logic [IW-1:0]    hit_slot_q;
	logic [CW-1:0]    cnt_q;
	logic [N-1:0]     valid_q;
	logic [CAP_W-1:0] cap_q;
	logic             out_vld_q;
	logic [STAT_W-1:0]    status_q;
	logic [SLOTOUT_W-1:0] slot_q;
	logic [CNTOUT_W-1:0]  count_q;

	logic             accept;
	logic             commit;
	logic [KW-1:0]    cap_ext;
	logic [KW-1:0]    cap_eff;
	logic             cap_full;
	logic [STAT_W-1:0] res_status;
	logic [IW-1:0]    res_slot;
	logic [CW-1:0]    cnt_nxt;
	logic [31:0]      res_slot_wide;
	logic [31:0]      cnt_nxt_wide;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign commit   = (state_q == S_COMMIT) && (!out_vld_q || !out_stall);
	assign in_stall = (state_q != S_IDLE);

	// Effective capacity is clipped to the store size.
	assign cap_ext  = KW'(cap_q);
	assign cap_eff  = (cap_ext > LIM) ? LIM : cap_ext;
	assign cap_full = KW'(cnt_q) >= cap_eff;

	// Result and update command of the item in hand.
	always_comb begin
		res_status = STAT_DONE;
		res_slot   = '0;
		cnt_nxt    = cnt_q;
		cmd.kind   = CMD_NONE;
		cmd.value  = key_q;
		cmd_pos    = hit_pos_q;
		cmd_slot   = free_slot_q;
		unique case (op_q)
			OP_APPEND: begin
				if (cap_full || !free_found_q) begin
					res_status = STAT_FULL;
				end else begin
					res_slot = free_slot_q;
					cnt_nxt  = cnt_q + 1'b1;
					cmd.kind = commit ? CMD_APPEND : CMD_NONE;
					cmd_pos  = cnt_q[IW-1:0];
				end
			end
			OP_DELETE: begin
				if (!found_q) begin
					res_status = STAT_MISSING;
				end else begin
					res_slot = hit_slot_q;
					cnt_nxt  = cnt_q - 1'b1;
					cmd.kind = commit ? CMD_DELETE : CMD_NONE;
				end
			end
			OP_MODIFY: begin
				if (!found_q) begin
					res_status = STAT_MISSING;
				end else begin
					res_slot  = hit_slot_q;
					cmd.kind  = commit ? CMD_MODIFY : CMD_NONE;
					cmd.value = new_q;
				end
			end
			OP_UNUSED: begin
				res_status = STAT_DONE;
			end
			default: begin
				res_status = STAT_DONE;
			end
		endcase
	end

	assign res_slot_wide = 32'(res_slot);
	assign cnt_nxt_wide  = 32'(cnt_nxt);

	// Control state, bookkeeping and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			launch_q     <= 1'b0;
			scan_q       <= '0;
			free_found_q <= 1'b0;
			cnt_q        <= '0;
			valid_q      <= '0;
			cap_q        <= CAP_RESET;
			out_vld_q    <= 1'b0;
		end else begin
			launch_q <= accept;
			if (wr_en) cap_q <= wr_data;
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q      <= S_WALK;
						scan_q       <= '0;
						free_found_q <= 1'b0;
					end
				end
				S_WALK: begin
					// Lowest free slot, one slot per cycle.
					if (!free_found_q && (scan_q != SCAN_END)) begin
						if (!valid_q[scan_q[IW-1:0]]) begin
							free_found_q <= 1'b1;
						end
						scan_q <= scan_q + 1'b1;
					end
					if (tok_end.vld) state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit) begin
						state_q   <= S_IDLE;
						cnt_q     <= cnt_nxt;
						if (cmd.kind == CMD_APPEND) valid_q[free_slot_q] <= 1'b1;
						if (cmd.kind == CMD_DELETE) valid_q[hit_slot_q] <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item payload, search result and result item fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			key_q <= key_value;
			new_q <= new_value;
		end
		if ((state_q == S_WALK) && !free_found_q && (scan_q != SCAN_END)) begin
			free_slot_q <= scan_q[IW-1:0];
		end
		if ((state_q == S_WALK) && tok_end.vld) begin
			found_q    <= tok_end.found;
			hit_pos_q  <= tok_end_pos;
			hit_slot_q <= tok_end_slot;
		end
		if (commit) begin
			status_q <= res_status;
			slot_q   <= res_slot_wide[SLOTOUT_W-1:0];
			count_q  <= cnt_nxt_wide[CNTOUT_W-1:0];
		end
	end

	assign tok_start.vld   = launch_q;
	assign tok_start.found = 1'b0;
	assign tok_start.key   = key_q;

	assign out_valid   = out_vld_q;
	assign status      = status_q;
	assign slot_used   = slot_q;
	assign entry_count = count_q;

	// Checks on the sequencer.
	`ALLE_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, KW'(cnt_q) <= LIM, "count above store size")
	`ALLE_ASSERT_IMP(a_map_pop, clk, arst_n, 1'b1, $countones(valid_q) == int'(cnt_q), "slot map and count disagree")
	`ALLE_ASSERT_IMP(a_fail_slot, clk, arst_n, out_vld_q && (status_q != STAT_DONE), slot_q == '0, "failed item reports a slot")
	`ALLE_ASSERT_IMP(a_tok_walk, clk, arst_n, tok_end.vld, state_q == S_WALK, "token arrived outside a walk")
	`ALLE_ASSERT_NXT(a_commit_out, clk, arst_n, commit, (state_q == S_IDLE) && out_vld_q, "commit without result item")

endmodule

@@ rtl/array_linked_list_engine.sv @@
// ---------------------------------------------------------------------------
// array_linked_list_engine
// Singly linked list of byte values in a fixed slot store: append, delete
// by key and modify by key, with a configurable capacity.
// ---------------------------------------------------------------------------
// The list is held in list order in a row of MAX_SLOTS cells, each holding
// one node's slot number and value. Every operation sends a search token
// down the row, one cell per cycle, while the sequencer scans the slot map
// for the lowest free slot; the update is then applied to all cells at once
// (a delete shifts later nodes forward). No new item is taken until the
// token has passed through the whole cell row and the item has committed. A
// finished result item waits in the output register; it does not block
// acceptance of the next item, but that item cannot finish until the
// waiting result has been taken, so output stalls add to the item time.
// Writes to the capacity register are taken in any cycle and are used by
// the next item to finish; make them while no item is in flight.
// ---------------------------------------------------------------------------
module array_linked_list_engine #(
	parameter int MAX_SLOTS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [alle_pkg::OP_W-1:0]      opcode,
	input  logic [alle_pkg::VAL_W-1:0]     key_value,
	input  logic [alle_pkg::VAL_W-1:0]     new_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [alle_pkg::STAT_W-1:0]    status,
	output logic [alle_pkg::SLOTOUT_W-1:0] slot_used,
	output logic [alle_pkg::CNTOUT_W-1:0]  entry_count,
	input  logic                           wr_en,
	input  logic [alle_pkg::CAP_W-1:0]     wr_data
);
	import alle_pkg::*;

	localparam int IW = $clog2(MAX_SLOTS);

	tok_ctl_t         tok_c      [0:MAX_SLOTS];
	logic [IW-1:0]    tok_pos_c  [0:MAX_SLOTS];
	logic [IW-1:0]    tok_slot_c [0:MAX_SLOTS];
	logic             occ_c      [0:MAX_SLOTS];
	logic [IW-1:0]    slot_c     [0:MAX_SLOTS];
	logic [VAL_W-1:0] val_c      [0:MAX_SLOTS];
	cmd_ctl_t         cmd;
	logic [IW-1:0]    cmd_pos;
	logic [IW-1:0]    cmd_slot;

	// Sequencer.
	alle_ctrl #(
		.N(MAX_SLOTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.key_value   (key_value),
		.new_value   (new_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.slot_used   (slot_used),
		.entry_count (entry_count),
		.wr_en       (wr_en),
		.wr_data     (wr_data),
		.tok_start   (tok_c[0]),
		.tok_end     (tok_c[MAX_SLOTS]),
		.tok_end_pos (tok_pos_c[MAX_SLOTS]),
		.tok_end_slot(tok_slot_c[MAX_SLOTS]),
		.cmd         (cmd),
		.cmd_pos     (cmd_pos),
		.cmd_slot    (cmd_slot)
	);

	// The token enters the row with no match recorded.
	assign tok_pos_c[0]  = '0;
	assign tok_slot_c[0] = '0;

	// Past the last cell the list is empty.
	assign occ_c[MAX_SLOTS]  = 1'b0;
	assign slot_c[MAX_SLOTS] = '0;
	assign val_c[MAX_SLOTS]  = '0;

	// Row of list cells.
	for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_row
		alle_cell #(
			.N  (MAX_SLOTS),
			.IDX(i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.tok_in      (tok_c[i]),
			.tok_pos_in  (tok_pos_c[i]),
			.tok_slot_in (tok_slot_c[i]),
			.tok_out     (tok_c[i+1]),
			.tok_pos_out (tok_pos_c[i+1]),
			.tok_slot_out(tok_slot_c[i+1]),
			.cmd         (cmd),
			.cmd_pos     (cmd_pos),
			.cmd_slot    (cmd_slot),
			.nxt_occ     (occ_c[i+1]),
			.nxt_slot    (slot_c[i+1]),
			.nxt_val     (val_c[i+1]),
			.occ         (occ_c[i]),
			.slot        (slot_c[i]),
			.val         (val_c[i])
		);
	end

endmodule

@@ sim/array_linked_list_engine_test.sv @@
// ---------------------------------------------------------------------------
// array_linked_list_engine_test
// Drives append, delete and modify items into the linked list engine under
// several capacity settings. A predictor in the bench mirrors the slot store
// and checks every result item against it, field by field.
// ---------------------------------------------------------------------------
module array_linked_list_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import alle_pkg::*;

	localparam int SLOTS          = 16;
	localparam int NONE           = SLOTS;
	localparam int SETTLE_CYCLES  = 2 * (SLOTS + 3) + 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 65;

	// One input item and one result item of the block.
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] key;
		logic [VAL_W-1:0] repl;
	} list_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]    stat;
		logic [SLOTOUT_W-1:0] slot;
		logic [CNTOUT_W-1:0]  count;
	} list_resp_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      opcode = '0;
	logic [VAL_W-1:0]     key_value = '0;
	logic [VAL_W-1:0]     new_value = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [STAT_W-1:0]    status;
	logic [SLOTOUT_W-1:0] slot_used;
	logic [CNTOUT_W-1:0]  entry_count;
	logic                 wr_en = 1'b0;
	logic [CAP_W-1:0]     wr_data = '0;

	// Mirror of the list state.
	logic [VAL_W-1:0] list_value [SLOTS];
	logic [4:0]       list_link  [SLOTS];
	logic             list_valid [SLOTS];
	logic [4:0]       list_head;
	logic [4:0]       list_tail;
	logic [4:0]       list_count;
	logic [CAP_W-1:0] list_cap;

	list_cmd_t  pending_ops[$];
	list_resp_t expected_replies[$];
	logic [VAL_W-1:0] key_pool [6];

	bit idle_on = 1'b1;
	bit in_taken = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	list_cmd_t  next_cmd;
	list_resp_t want;

	array_linked_list_engine #(
		.MAX_SLOTS(SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.key_value(key_value),
		.new_value(new_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.slot_used(slot_used),
		.entry_count(entry_count),
		.wr_en(wr_en),
		.wr_data(wr_data)
	);

	// Clock generation.
	initial begin
		forever #5 clk = ~clk;
	end

	// Length of an idle gap or a stall run: mostly short, a few long.
	function automatic int draw_idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Applies one item to the mirrored list and returns the result it causes.
	function automatic list_resp_t apply_list_op(list_cmd_t c);
		list_resp_t r;
		int cap, cur, prev, hit, steps;
		r.stat = STAT_DONE;
		r.slot = '0;
		cap = (list_cap > SLOTS) ? SLOTS : int'(list_cap);
		hit = NONE;
		prev = NONE;
		case (c.op)
			OP_APPEND: begin
				if (list_count >= cap) begin
					r.stat = STAT_FULL;
				end else begin
					for (int s = SLOTS - 1; s >= 0; s--)
						if (!list_valid[s])
							hit = s;
					if (hit == NONE) begin
						r.stat = STAT_FULL;
					end else begin
						list_value[hit] = c.key;
						list_link[hit] = NONE;
						list_valid[hit] = 1'b1;
						if (list_tail < NONE && list_count > 0)
							list_link[list_tail] = hit;
						else
							list_head = hit;
						list_tail = hit;
						list_count++;
						r.slot = 4'(hit);
					end
				end
			end
			OP_DELETE, OP_MODIFY: begin
				// Walk from the head until the first node holding the key.
				cur = list_head;
				steps = 0;
				while (cur < NONE && steps < list_count && hit == NONE) begin
					if (list_valid[cur] && list_value[cur] == c.key) begin
						hit = cur;
					end else begin
						prev = cur;
						cur = list_link[cur];
						steps++;
					end
				end
				if (hit == NONE) begin
					r.stat = STAT_MISSING;
				end else if (c.op == OP_MODIFY) begin
					list_value[hit] = c.repl;
					r.slot = 4'(hit);
				end else begin
					if (prev == NONE)
						list_head = list_link[hit];
					else
						list_link[prev] = list_link[hit];
					if (list_tail == hit)
						list_tail = prev;
					if (list_count > 0)
						list_count--;
					if (list_count == 0) begin
						list_head = NONE;
						list_tail = NONE;
					end
					list_valid[hit] = 1'b0;
					list_link[hit] = NONE;
					r.slot = 4'(hit);
				end
			end
			default: begin
			end
		endcase
		r.count = list_count;
		return r;
	endfunction

	task automatic push_op(logic [OP_W-1:0] op, logic [VAL_W-1:0] key,
			logic [VAL_W-1:0] repl);
		list_cmd_t c;
		c.op = op;
		c.key = key;
		c.repl = repl;
		pending_ops.push_back(c);
	endtask

	function automatic logic [VAL_W-1:0] draw_key();
		if ($urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, 5)];
		return 8'($urandom_range(0, 255));
	endfunction

	// Random items over a small key pool, so that deletes and modifies
	// often hit and duplicate keys are common.
	task automatic queue_random_ops(int n, int append_pct);
		int r;
		logic [OP_W-1:0] op;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < append_pct)
				op = OP_APPEND;
			else if (r < 95)
				op = $urandom_range(0, 1) ? OP_DELETE : OP_MODIFY;
			else
				op = OP_UNUSED;
			push_op(op, draw_key(), $urandom_range(0, 1) ? draw_key() :
				8'($urandom_range(0, 255)));
		end
	endtask

	task automatic wait_idle();
		while (pending_ops.size() != 0 || in_valid || expected_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_data <= value;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// Input driver: holds an item until it is taken, then moves on.
	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left--;
		end else if (pending_ops.size() != 0) begin
			next_cmd = pending_ops.pop_front();
			opcode <= next_cmd.op;
			key_value <= next_cmd.key;
			new_value <= next_cmd.repl;
			in_valid <= 1'b1;
			gap_left = draw_idle_len();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result side back pressure.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = draw_idle_len();
		end
	end

	// Monitor: predicts on each accepted item and checks each result item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en)
				list_cap = wr_data;
			in_taken = in_valid && !in_stall;
			if (in_taken) begin
				next_cmd.op = opcode;
				next_cmd.key = key_value;
				next_cmd.repl = new_value;
				expected_replies.push_back(apply_list_op(next_cmd));
			end
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d slot %0d count %0d",
							status, slot_used, entry_count);
				end else begin
					want = expected_replies.pop_front();
					if (status !== want.stat || slot_used !== want.slot ||
							entry_count !== want.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"result mismatch: expected status %0d slot %0d ",
								"count %0d, got status %0d slot %0d count %0d"},
								want.stat, want.slot, want.count,
								status, slot_used, entry_count);
					end
				end
			end
		end
	end

	// Watchdog: ends the run when work is pending but nothing moves.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(pending_ops.size() == 0 && expected_replies.size() == 0 && !in_valid))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		int caps[$];
		int cap;
		for (int s = 0; s < SLOTS; s++) begin
			list_value[s] = '0;
			list_link[s] = NONE;
			list_valid[s] = 1'b0;
		end
		list_head = NONE;
		list_tail = NONE;
		list_count = '0;
		list_cap = CAP_RESET;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset capacity of five.
		push_op(OP_DELETE, 8'h00, 8'h00);
		push_op(OP_MODIFY, 8'hFF, 8'h11);
		push_op(OP_UNUSED, 8'hFF, 8'hFF);
		push_op(OP_APPEND, 8'h00, 8'hFF);
		push_op(OP_APPEND, 8'hFF, 8'h00);
		push_op(OP_APPEND, 8'h00, 8'h00);
		push_op(OP_APPEND, 8'h07, 8'h00);
		push_op(OP_APPEND, 8'hC8, 8'h00);
		push_op(OP_APPEND, 8'h01, 8'h00);
		push_op(OP_MODIFY, 8'h00, 8'h09);
		push_op(OP_DELETE, 8'h00, 8'h00);
		push_op(OP_DELETE, 8'h09, 8'h00);
		push_op(OP_DELETE, 8'hC8, 8'h00);
		push_op(OP_APPEND, 8'h2A, 8'h00);
		push_op(OP_UNUSED, 8'h2A, 8'h2A);
		push_op(OP_DELETE, 8'hFF, 8'h00);
		push_op(OP_DELETE, 8'h07, 8'h00);
		push_op(OP_DELETE, 8'h2A, 8'h00);
		push_op(OP_APPEND, 8'h55, 8'h00);
		push_op(OP_MODIFY, 8'hAA, 8'h00);
		push_op(OP_DELETE, 8'h55, 8'h00);

		// Capacity settings: the store size, a drop below the node count,
		// values above the store, the minimum and zero, then random ones.
		caps = '{16, 2, 31, 1, 0, 17};
		repeat (4) caps.push_back($urandom_range(0, 31));
		foreach (caps[p]) begin
			wait_idle();
			cap = caps[p];
			write_capacity(CAP_W'(cap));
			idle_on = ($urandom_range(0, 3) != 0);
			key_pool[0] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
			for (int k = 1; k < 6; k++)
				key_pool[k] = $urandom_range(0, 255);
			if (cap == SLOTS)
				repeat (SLOTS + 1) push_op(OP_APPEND, draw_key(), 8'h00);
			queue_random_ops(PHASE_ITEMS, $urandom_range(25, 55));
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ array_linked_list_engine.f @@
+incdir+rtl
rtl/alle_pkg.sv
rtl/alle_cell.sv
rtl/alle_ctrl.sv
rtl/array_linked_list_engine.sv
sim/array_linked_list_engine_test.sv
